FILE: src/sbie_pkg.sv
package sbie_pkg;

    // bit set geometry
    localparam int WORDS      = 1024;
    localparam int WORD_BITS  = 64;
    localparam int OFF_W      = $clog2(WORD_BITS);
    localparam int POS_W      = $clog2(WORDS + 1);
    localparam int IDX_W      = 16;
    localparam int LIMIT_W    = 17;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65536);
    localparam logic [LIMIT_W-1:0] COUNT_MAX   = '1;
    localparam logic [POS_W-1:0]   POS_END     = POS_W'(WORDS);
    localparam logic [WORD_BITS-1:0] WORD_MSB  = {1'b1, {(WORD_BITS-1){1'b0}}};

    // input request
    typedef struct packed {
        logic [WORD_BITS-1:0] word_bits;
        logic                 first_word;
    } t_in_item;

    // result request
    typedef struct packed {
        logic [IDX_W-1:0] entry_index;
        logic             last_in_word;
        logic             limit_hit;
    } t_out_item;

    // classified word passed from front to back
    typedef struct packed {
        logic [WORD_BITS-1:0] word_bits;
        logic [POS_W-1:0]     pos;
        logic                 first_word;
    } t_work;

    // back end status seen by the top level
    typedef struct packed {
        logic busy;
        logic stopped;
    } t_back_status;

    // distance of the highest set bit from the msb
    function automatic logic [OFF_W-1:0] lead_zeros(input logic [WORD_BITS-1:0] w);
        logic [OFF_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (w[i]) begin
                r = OFF_W'(WORD_BITS - 1 - i);
            end
        end
        return r;
    endfunction

endpackage

FILE: src/sbie_if.sv
interface sbie_in_if;
    import sbie_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sbie_work_if;
    import sbie_pkg::*;
    logic  valid;
    logic  ready;
    t_work payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sbie_out_if;
    import sbie_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/sbie_front.sv
module sbie_front (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sbie_in_if.sink     i_in,
    sbie_work_if.source o_work
);
    import sbie_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] w_pos_eff;
    logic             w_drop;
    logic             w_accept;

    // position of this word, restarted by a first word
    assign w_pos_eff = i_in.payload.first_word ? '0 : r_pos;

    // words that cannot emit or change back end state are dropped here
    assign w_drop = !i_in.payload.first_word &&
                    ((r_pos >= POS_END) || (i_in.payload.word_bits == '0));

    assign i_in.ready   = o_work.ready;
    assign w_accept     = i_in.valid && i_in.ready;
    assign o_work.valid = i_in.valid && !w_drop;

    assign o_work.payload.word_bits  = i_in.payload.word_bits;
    assign o_work.payload.pos        = w_pos_eff;
    assign o_work.payload.first_word = i_in.payload.first_word;

    // saturating word position
    assign n_pos = (w_pos_eff < POS_END) ? w_pos_eff + POS_W'(1) : w_pos_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_accept) begin
            r_pos <= n_pos;
        end
    end

endmodule

FILE: src/sbie_queue.sv
module sbie_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sbie_work_if.sink   i_push,
    sbie_work_if.source o_pop
);
    import sbie_pkg::*;

    t_work              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0]  r_cnt;
    logic               w_push;
    logic               w_pop;

    assign i_push.ready  = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_pop.valid   = (r_cnt != '0);
    assign o_pop.payload = r_mem[r_rp];

    assign w_push = i_push.valid && i_push.ready;
    assign w_pop  = o_pop.valid && o_pop.ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push.payload;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

FILE: src/sbie_back.sv
module sbie_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [sbie_pkg::LIMIT_W-1:0] i_limit,
    sbie_work_if.sink                i_work,
    sbie_out_if.source               o_out,
    output sbie_pkg::t_back_status   o_status
);
    import sbie_pkg::*;

    logic                 r_busy;
    logic                 r_stopped;
    logic [LIMIT_W-1:0]   r_count;
    logic [WORD_BITS-1:0] r_word;
    logic [POS_W-1:0]     r_pos;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 w_pop;
    logic                 w_stop_eff;
    logic                 w_can_emit;
    logic                 w_step;
    logic [OFF_W-1:0]     w_lz;
    logic [WORD_BITS-1:0] w_rest;
    logic [LIMIT_W-1:0]   n_count;
    logic                 w_hit;
    logic                 w_last;

    // one word is loaded while the scanner is idle
    assign i_work.ready = !r_busy;
    assign w_pop        = i_work.valid && i_work.ready;
    assign w_stop_eff   = i_work.payload.first_word ? 1'b0 : r_stopped;

    // scan step: highest remaining bit, one result per cycle while the output is not stalled
    assign w_can_emit = !r_out_valid || o_out.ready;
    assign w_step     = r_busy && w_can_emit;
    assign w_lz       = lead_zeros(r_word);
    assign w_rest     = r_word & ~(WORD_MSB >> w_lz);
    assign n_count    = (r_count < COUNT_MAX) ? r_count + LIMIT_W'(1) : r_count;
    assign w_hit      = (n_count == i_limit);
    assign w_last     = (w_rest == '0) || w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_stopped <= 1'b0;
            r_count   <= '0;
        end else if (w_pop) begin
            if (i_work.payload.first_word) begin
                r_count   <= '0;
                r_stopped <= 1'b0;
            end
            r_busy <= !w_stop_eff && (i_work.payload.word_bits != '0);
        end else if (w_step) begin
            r_count <= n_count;
            if (w_hit) begin
                r_stopped <= 1'b1;
            end
            if (w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // word under scan
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_word <= i_work.payload.word_bits;
            r_pos  <= i_work.payload.pos;
        end else if (w_step) begin
            r_word <= w_rest;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out.entry_index  <= IDX_W'({r_pos, w_lz});
            r_out.last_in_word <= w_last;
            r_out.limit_hit    <= w_hit;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.payload    = r_out;
    assign o_status.busy    = r_busy;
    assign o_status.stopped = r_stopped;

endmodule

FILE: src/set_bit_index_enumerator.sv
// path: an accepted word is queued, then loaded into the scanner registers when
// the scanner is idle; each result leaves through the registered output
// throughput: the single scan unit loads a word, then emits its indices in turn;
// no new word till done; dropped words pass one per cycle while the queue has room
// reset: synchronous, active low; clears word position, count, stop flag, queue,
// and sets result_limit to 65536
module set_bit_index_enumerator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    sbie_in_if.sink                      i_in,
    sbie_out_if.source                   o_out,
    input  logic                         i_cfg_we,
    input  logic [sbie_pkg::LIMIT_W-1:0] i_cfg_wdata
);
    import sbie_pkg::*;

    logic [LIMIT_W-1:0] r_result_limit;
    t_back_status       w_status;

    sbie_work_if w_front_q ();
    sbie_work_if w_q_back ();

    // limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_result_limit <= i_cfg_wdata;
        end
    end

    // classify and number the words
    sbie_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_work  (w_front_q)
    );

    // decoupling queue
    sbie_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_q),
        .o_pop   (w_q_back)
    );

    // scan words and emit indices
    sbie_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_limit  (r_result_limit),
        .i_work   (w_q_back),
        .o_out    (o_out),
        .o_status (w_status)
    );

    // a result that reaches the limit closes its word
    a_hit_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload.limit_hit |-> o_out.payload.last_in_word)
        else $error("limit result without last_in_word");

    // once stopped the scanner holds no word
    a_stopped_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.stopped |-> !w_status.busy)
        else $error("scanner busy while stopped");

    // a limit hit leaves the back end stopped
    a_hit_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) && o_out.payload.limit_hit |-> w_status.stopped)
        else $error("limit hit did not stop the set");

endmodule
